// File: src/spq_pkg.sv
package spq_pkg;

    // Queue geometry
    localparam int DEPTH    = 16;
    localparam int ID_W     = 16;
    localparam int PRI_W    = 2;
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int OCNT_W   = 5;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL_POS   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    // One queue slot
    typedef struct packed {
        logic             vld;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_entry;

    // What a cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD_NEW,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_cell_ctrl;

endpackage

// File: src/spq_if.sv
interface spq_req_if;
    logic                        valid;
    logic                        ready;
    logic [spq_pkg::FUNC_W-1:0]  func;
    logic [spq_pkg::ID_W-1:0]    member_id;
    logic [spq_pkg::PRI_W-1:0]   priority_req;
    logic [spq_pkg::POS_W-1:0]   position;

    modport source (output valid, func, member_id, priority_req, position, input ready);
    modport sink   (input valid, func, member_id, priority_req, position, output ready);
endinterface

interface spq_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [spq_pkg::STAT_W-1:0]  status;
    logic                        removed_valid;
    logic [spq_pkg::ID_W-1:0]    removed_id;
    logic [spq_pkg::PRI_W-1:0]   removed_priority;
    logic [spq_pkg::OCNT_W-1:0]  entry_count;
    logic [spq_pkg::ID_W-1:0]    head_id;
    logic [spq_pkg::PRI_W-1:0]   head_priority;

    modport source (output valid, status, removed_valid, removed_id, removed_priority,
                    entry_count, head_id, head_priority, input ready);
    modport sink   (input valid, status, removed_valid, removed_id, removed_priority,
                    entry_count, head_id, head_priority, output ready);
endinterface

// File: src/spq_cell.sv
module spq_cell import spq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_left,
    input  t_entry     i_right,
    output t_entry     o_cur,
    output t_entry     o_nxt,
    output logic       o_after
);

    logic             r_vld;
    logic [ID_W-1:0]  r_id;
    logic [PRI_W-1:0] r_pri;
    t_entry           n_ent;

    assign o_cur = '{vld: r_vld, id: r_id, pri: r_pri};

    // New entry belongs at or before this slot (empty, or lower priority held)
    assign o_after = !r_vld || (r_pri < i_ctrl.pri);

    // Next slot contents
    always_comb begin
        case (i_ctrl.op)
            CELL_LOAD_NEW:   n_ent = '{vld: 1'b1, id: i_ctrl.id, pri: i_ctrl.pri};
            CELL_FROM_LEFT:  n_ent = i_left;
            CELL_FROM_RIGHT: n_ent = i_right;
            default:         n_ent = o_cur;
        endcase
    end

    assign o_nxt = n_ent;

    // Valid flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_ent.vld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_id  <= n_ent.id;
        r_pri <= n_ent.pri;
    end

endmodule

// File: src/stable_priority_queue_core.sv
// Channel  Modport         Direction  Contents
// i_req    spq_req_if.sink    in      func, member_id, priority_req, position
// o_rsp    spq_rsp_if.source  out     status, removed entry, entry_count, head
//
// Each request is captured in S_IDLE; in S_EXEC every cell of
// the row loads the new entry, shifts from a neighbor or holds; depth-independent.
// The result sits in an output register; a new request is taken while it waits.
// If the result register is still occupied, execution holds until it drains.
// Synchronous active-low reset clears the state, the result valid, the cell
// valid flags and the count; payload registers are left as they are.
module stable_priority_queue_core import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state             r_state;
    logic [FUNC_W-1:0]  r_func;
    logic [ID_W-1:0]    r_id;
    logic [PRI_W-1:0]   r_pri;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_count;
    logic               r_out_valid;
    logic [STAT_W-1:0]  r_status;
    logic               r_rm_valid;
    logic [ID_W-1:0]    r_rm_id;
    logic [PRI_W-1:0]   r_rm_pri;
    logic [CNT_W-1:0]   r_out_count;
    logic [ID_W-1:0]    r_head_id;
    logic [PRI_W-1:0]   r_head_pri;

    t_entry             w_cur   [DEPTH];
    t_entry             w_nxt   [DEPTH];
    t_entry             w_left  [DEPTH];
    t_entry             w_right [DEPTH];
    t_cell_ctrl         w_ctrl  [DEPTH];
    logic [DEPTH-1:0]   w_after;
    logic [DEPTH-1:0]   w_vld;

    logic               w_fire;
    logic               w_full;
    logic               w_empty;
    logic               w_bad_pos;
    logic [CMP_W-1:0]   w_pos_ext;
    logic [CMP_W-1:0]   w_del_idx;
    logic               w_do_ins;
    logic               w_do_del;
    logic [STAT_W-1:0]  w_status;
    logic [CNT_W-1:0]   n_count;
    t_entry             w_removed;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_fire      = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // Request decode
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_pos_ext = CMP_W'(r_pos);
    assign w_bad_pos = (w_pos_ext == '0) || (w_pos_ext > CMP_W'(r_count));
    assign w_del_idx = (r_func == FUNC_DEL_POS) ? (w_pos_ext - CMP_W'(1)) : '0;

    always_comb begin
        w_status = ST_OK;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        case (r_func)
            FUNC_INSERT: begin
                if (w_full) w_status = ST_FULL;
                else        w_do_ins = 1'b1;
            end
            FUNC_DEL_FRONT: begin
                if (w_empty) w_status = ST_EMPTY;
                else         w_do_del = 1'b1;
            end
            FUNC_DEL_POS: begin
                if (w_empty)        w_status = ST_EMPTY;
                else if (w_bad_pos) w_status = ST_RANGE;
                else                w_do_del = 1'b1;
            end
            default: w_status = ST_OK;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_do_ins)      n_count = r_count + CNT_W'(1);
        else if (w_do_del) n_count = r_count - CNT_W'(1);
    end

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_left[i] = '0;
        end else begin : g_mid_l
            assign w_left[i] = w_cur[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right[i] = '0;
        end else begin : g_mid_r
            assign w_right[i] = w_cur[i+1];
        end

        logic w_first_after;
        if (i == 0) begin : g_fa0
            assign w_first_after = w_after[i];
        end else begin : g_fan
            assign w_first_after = w_after[i] && !w_after[i-1];
        end

        // Insert: first slot after the higher-or-equal run loads, later ones shift down.
        // Delete: the chosen slot and all behind it take from the right.
        always_comb begin
            w_ctrl[i].id  = r_id;
            w_ctrl[i].pri = r_pri;
            w_ctrl[i].op  = CELL_HOLD;
            if (w_fire && w_do_ins && w_first_after) begin
                w_ctrl[i].op = CELL_LOAD_NEW;
            end else if (w_fire && w_do_ins && w_after[i]) begin
                w_ctrl[i].op = CELL_FROM_LEFT;
            end else if (w_fire && w_do_del && (CMP_W'(i) >= w_del_idx)) begin
                w_ctrl[i].op = CELL_FROM_RIGHT;
            end
        end

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[i]),
            .i_left  (w_left[i]),
            .i_right (w_right[i]),
            .o_cur   (w_cur[i]),
            .o_nxt   (w_nxt[i]),
            .o_after (w_after[i])
        );

        assign w_vld[i] = w_cur[i].vld;
    end

    // Pick out the removed entry
    always_comb begin
        w_removed = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (CMP_W'(j) == w_del_idx) w_removed = w_removed | w_cur[j];
        end
    end

    // Control, request capture, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire)           r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func  <= i_req.func;
                        r_id    <= i_req.member_id;
                        r_pri   <= i_req.priority_req;
                        r_pos   <= i_req.position;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_count     <= n_count;
                        r_status    <= w_status;
                        r_rm_valid  <= w_do_del;
                        r_rm_id     <= w_do_del ? w_removed.id : '0;
                        r_rm_pri    <= w_do_del ? w_removed.pri : '0;
                        r_out_count <= n_count;
                        r_head_id   <= w_nxt[0].vld ? w_nxt[0].id : '0;
                        r_head_pri  <= w_nxt[0].vld ? w_nxt[0].pri : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_status;
    assign o_rsp.removed_valid    = r_rm_valid;
    assign o_rsp.removed_id       = r_rm_id;
    assign o_rsp.removed_priority = r_rm_pri;
    assign o_rsp.entry_count      = OCNT_W'(r_out_count);
    assign o_rsp.head_id          = r_head_id;
    assign o_rsp.head_priority    = r_head_pri;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_valid_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) == r_count)
        else $error("cell valid flags disagree with count");

    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rm_valid |-> r_status == ST_OK)
        else $error("removal reported with error status");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_do_ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the queue");

endmodule
